@@ src/cpp_pkg.sv @@
package cpp_pkg;

   localparam int FIELD_W     = 16;
   localparam int IN_DATA_W   = 32;
   localparam int DIST_W      = 34;
   localparam int IDX_OUT_W   = 10;
   localparam int OUT_DATA_W  = 120;
   localparam int OUT_USER_W  = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(64'd1 << 33);
   localparam logic [DIST_W-1:0] DIST_MAX  = '1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SEARCH,
      ST_DRAIN,
      ST_EMIT
   } back_state_type;

   // first member sits in the high bits
   typedef struct packed {
      logic [FIELD_W-1:0]   second_y;
      logic [FIELD_W-1:0]   second_x;
      logic [FIELD_W-1:0]   first_y;
      logic [FIELD_W-1:0]   first_x;
      logic [IDX_OUT_W-1:0] second_index;
      logic [IDX_OUT_W-1:0] first_index;
      logic [DIST_W-1:0]    best_dist_sq;
   } rsp_fields_type;

   typedef struct packed {
      logic overflow;
      logic found;
   } rsp_flags_type;

endpackage

@@ src/cpp_front.sv @@
module cpp_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cpp_pkg::IN_DATA_W-1:0]      req_tdata,
   input  logic                               req_tlast,
   output logic                               push_valid,
   input  logic                               push_ready,
   output logic [2*COORD_BITS:0]              push_data
);

   localparam int C = COORD_BITS;

   logic                 hold_valid_ff;
   logic                 hold_valid_in;
   logic [2*C:0]         hold_data_ff;
   logic [31:0]          ext_x;
   logic [31:0]          ext_y;
   logic                 accept;

   // trim or sign-extend each field to the working coordinate width
   assign ext_x  = 32'(signed'(req_tdata[cpp_pkg::FIELD_W-1:0]));
   assign ext_y  = 32'(signed'(req_tdata[2*cpp_pkg::FIELD_W-1:cpp_pkg::FIELD_W]));

   assign req_tready = !hold_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;
   assign push_data  = hold_data_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_data_ff <= {req_tlast, ext_y[C-1:0], ext_x[C-1:0]};
      end
   end

endmodule

@@ src/cpp_queue.sv @@
module cpp_queue #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = cpp_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [PW:0]      fill_ff;
   logic [PW:0]      fill_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = fill_ff != (PW+1)'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/cpp_back.sv @@
module cpp_back #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  logic [2*COORD_BITS:0]               pop_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output cpp_pkg::rsp_fields_type             rsp_fields,
   output cpp_pkg::rsp_flags_type              rsp_flags
);

   localparam int C    = COORD_BITS;
   localparam int IDXW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int SQW  = 2 * C;
   localparam int SUMW = 2 * C + 1;

   cpp_pkg::back_state_type state_ff;
   cpp_pkg::back_state_type state_in;

   logic [2*C-1:0]  mem [MAX_POINTS];

   logic [CNTW-1:0] cnt_ff;
   logic [CNTW-1:0] cnt_in;
   logic            ovf_ff;
   logic            ovf_in;
   logic [IDXW-1:0] i_ff;
   logic [IDXW-1:0] i_in;
   logic [IDXW-1:0] j_ff;
   logic [IDXW-1:0] j_in;

   logic            pop;
   logic            issue;
   logic            emit;
   logic            has_room;
   logic            item_last;
   logic [CNTW-1:0] cnt_after;
   logic            row_end;
   logic            last_pair;
   logic            pipe_busy;

   // pipeline
   logic            v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDXW-1:0] i1_ff, j1_ff, i2_ff, j2_ff, i3_ff, j3_ff, i4_ff, j4_ff;
   logic [2*C-1:0]  rd_a_ff, rd_b_ff;
   logic [2*C-1:0]  pa2_ff, pb2_ff, pa3_ff, pb3_ff, pa4_ff, pb4_ff;
   logic [C-1:0]    dx_ff, dy_ff;
   logic [SQW-1:0]  sqx_ff, sqy_ff;
   logic [SUMW-1:0] sum_ff;
   logic [C:0]      diff_x;
   logic [C:0]      diff_y;
   logic [C:0]      abs_x;
   logic [C:0]      abs_y;

   // best so far
   logic            have_ff;
   logic [SUMW-1:0] best_ff;
   logic [IDXW-1:0] bi_ff, bj_ff;
   logic [2*C-1:0]  bpa_ff, bpb_ff;
   logic            better;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;

   logic [63:0]     best64;
   logic [31:0]     bi32, bj32;
   logic [31:0]     fx32, fy32, sx32, sy32;
   cpp_pkg::rsp_fields_type fields_now;

   assign has_room  = cnt_ff < CNTW'(MAX_POINTS);
   assign item_last = pop_data[2*C];
   assign cnt_after = (pop && has_room) ? cnt_ff + 1'b1 : cnt_ff;
   assign row_end   = CNTW'(j_ff) == cnt_ff - 1'b1;
   assign last_pair = row_end && (CNTW'(i_ff) == cnt_ff - CNTW'(2));
   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;

   // output decode
   always_comb begin
      pop   = 1'b0;
      issue = 1'b0;
      emit  = 1'b0;
      case (state_ff)
         cpp_pkg::ST_LOAD:   pop   = pop_valid;
         cpp_pkg::ST_SEARCH: issue = 1'b1;
         cpp_pkg::ST_EMIT:   emit  = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign pop_ready = pop;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpp_pkg::ST_LOAD: begin
            if (pop && item_last) begin
               state_in = (cnt_after >= CNTW'(2)) ? cpp_pkg::ST_SEARCH : cpp_pkg::ST_EMIT;
            end
         end
         cpp_pkg::ST_SEARCH: begin
            if (last_pair) begin
               state_in = cpp_pkg::ST_DRAIN;
            end
         end
         cpp_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = cpp_pkg::ST_EMIT;
            end
         end
         cpp_pkg::ST_EMIT: begin
            if (emit) begin
               state_in = cpp_pkg::ST_LOAD;
            end
         end
         default: state_in = cpp_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cnt_in = cnt_after;
      ovf_in = ovf_ff || (pop && !has_room);
      i_in   = i_ff;
      j_in   = j_ff;
      if (pop && item_last) begin
         i_in = '0;
         j_in = IDXW'(1);
      end else if (issue) begin
         if (row_end) begin
            i_in = i_ff + 1'b1;
            j_in = i_ff + IDXW'(2);
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
      if (emit) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpp_pkg::ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         if (pop && item_last) begin
            have_ff <= 1'b0;
         end else if (better) begin
            have_ff <= 1'b1;
         end
      end
   end

   // point store
   always_ff @(posedge clock) begin
      if (pop && has_room) begin
         mem[cnt_ff[IDXW-1:0]] <= pop_data[2*C-1:0];
      end
      rd_a_ff <= mem[i_ff];
      rd_b_ff <= mem[j_ff];
   end

   assign diff_x = {rd_a_ff[C-1], rd_a_ff[C-1:0]} - {rd_b_ff[C-1], rd_b_ff[C-1:0]};
   assign diff_y = {rd_a_ff[2*C-1], rd_a_ff[2*C-1:C]} - {rd_b_ff[2*C-1], rd_b_ff[2*C-1:C]};
   assign abs_x  = diff_x[C] ? (C+1)'(~diff_x + 1'b1) : diff_x;
   assign abs_y  = diff_y[C] ? (C+1)'(~diff_y + 1'b1) : diff_y;
   assign better = v4_ff && (!have_ff || (sum_ff < best_ff));

   always_ff @(posedge clock) begin
      i1_ff  <= i_ff;
      j1_ff  <= j_ff;
      dx_ff  <= abs_x[C-1:0];
      dy_ff  <= abs_y[C-1:0];
      i2_ff  <= i1_ff;
      j2_ff  <= j1_ff;
      pa2_ff <= rd_a_ff;
      pb2_ff <= rd_b_ff;
      sqx_ff <= SQW'(dx_ff) * SQW'(dx_ff);
      sqy_ff <= SQW'(dy_ff) * SQW'(dy_ff);
      i3_ff  <= i2_ff;
      j3_ff  <= j2_ff;
      pa3_ff <= pa2_ff;
      pb3_ff <= pb2_ff;
      sum_ff <= SUMW'(sqx_ff) + SUMW'(sqy_ff);
      i4_ff  <= i3_ff;
      j4_ff  <= j3_ff;
      pa4_ff <= pa3_ff;
      pb4_ff <= pb3_ff;
      if (better) begin
         best_ff <= sum_ff;
         bi_ff   <= i4_ff;
         bj_ff   <= j4_ff;
         bpa_ff  <= pa4_ff;
         bpb_ff  <= pb4_ff;
      end
   end

   // result formatting
   assign best64 = 64'(best_ff);
   assign bi32   = 32'(bi_ff);
   assign bj32   = 32'(bj_ff);
   assign fx32   = 32'(signed'(bpa_ff[C-1:0]));
   assign fy32   = 32'(signed'(bpa_ff[2*C-1:C]));
   assign sx32   = 32'(signed'(bpb_ff[C-1:0]));
   assign sy32   = 32'(signed'(bpb_ff[2*C-1:C]));

   always_comb begin
      fields_now = '0;
      fields_now.best_dist_sq = cpp_pkg::DIST_NONE;
      if (have_ff) begin
         fields_now.best_dist_sq = (best64 > 64'(cpp_pkg::DIST_MAX)) ?
                                   cpp_pkg::DIST_MAX : best64[cpp_pkg::DIST_W-1:0];
         fields_now.first_index  = bi32[cpp_pkg::IDX_OUT_W-1:0];
         fields_now.second_index = bj32[cpp_pkg::IDX_OUT_W-1:0];
         fields_now.first_x      = fx32[cpp_pkg::FIELD_W-1:0];
         fields_now.first_y      = fy32[cpp_pkg::FIELD_W-1:0];
         fields_now.second_x     = sx32[cpp_pkg::FIELD_W-1:0];
         fields_now.second_y     = sy32[cpp_pkg::FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_fields     <= fields_now;
         rsp_flags.found    <= have_ff;
         rsp_flags.overflow <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpp_pkg::ST_EMIT) |-> !pipe_busy)
      else $error("result formed while distance pipeline busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(MAX_POINTS))
      else $error("point count past store depth");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      issue |-> ((i_ff < j_ff) && (CNTW'(j_ff) < cnt_ff)))
      else $error("pair index out of order or range");

   a_no_pop_in_search: assert property (@(posedge clock) disable iff (reset)
      issue |-> !pop)
      else $error("point taken during search");

endmodule

@@ src/closest_pair_of_points.sv @@
// Closest pair of points, brute force over all pairs.
//
// req channel: one point per item, tdata = {point_y, point_x}, tlast marks
// the final point of a set. Points are trimmed to COORD_BITS, go through a
// small queue, and are written to a MAX_POINTS-entry store one per cycle
// in the load state. Points past capacity are dropped and flag overflow.
//
// rsp channel: one item per set, issued after the item marked tlast.
// After the last point, the search checks every pair i<j, one per cycle,
// through a pipelined store read, difference, square and sum; with fewer
// than two stored points it is skipped. Loading runs at one item per cycle
// in the load state only; the next set may load while a result still waits.
//
// Reset clears control state only; no store clearing is needed.
// When rsp_tready is low the result holds in its output register; once the
// next set's search ends, the block waits for that register to drain.
module closest_pair_of_points #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cpp_pkg::IN_DATA_W-1:0]        req_tdata,   // point_x, point_y
   input  logic                                 req_tlast,   // last_point
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // best_dist_sq, first_index, second_index, first_x, first_y, second_x,
   // second_y, zero pad
   output logic [cpp_pkg::OUT_DATA_W-1:0]       rsp_tdata,
   output logic [cpp_pkg::OUT_USER_W-1:0]       rsp_tuser    // found, overflow
);

   localparam int EW = 2 * COORD_BITS + 1;

   logic                    push_valid;
   logic                    push_ready;
   logic [EW-1:0]           push_data;
   logic                    q_valid;
   logic                    q_ready;
   logic [EW-1:0]           q_data;
   cpp_pkg::rsp_fields_type rsp_fields;
   cpp_pkg::rsp_flags_type  rsp_flags;

   cpp_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cpp_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   cpp_back #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_fields (rsp_fields),
      .rsp_flags  (rsp_flags)
   );

   assign rsp_tdata = cpp_pkg::OUT_DATA_W'(rsp_fields);
   assign rsp_tuser = rsp_flags;

endmodule
